// ===== rtl/core/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// bde_pkg: shared types and constants for the backslash escape decoder
// Character codes, reset values and the structs passed between the stages.
// ----------------------------------------------------------------------------
package bde_pkg;

    // Characters that the decoder recognizes
    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_C         = 8'h63;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_X_LOWER   = 8'h78;
    localparam logic [7:0] CHAR_X_UPPER   = 8'h58;

    // Control codes produced by the named escapes
    localparam logic [7:0] CODE_LF = 8'd10;
    localparam logic [7:0] CODE_HT = 8'd9;
    localparam logic [7:0] CODE_CR = 8'd13;

    // Decode modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_HEX   = 2'd2;
    localparam logic [1:0] MODE_OCT   = 2'd3;

    // Reset value of the color escape register
    localparam logic [7:0] COLOR_CODE_RESET = 8'd28;

    // Most results one request can produce
    localparam int unsigned MAX_RESULTS = 3;

    // Decoder state
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] value;
        logic [1:0] count;
        logic [7:0] held_byte;
        logic       held_valid;
    } bde_state_t;

    // One decoded result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } bde_result_t;

    // All results of one request, slot 0 first
    typedef struct packed {
        bde_result_t [MAX_RESULTS-1:0] slot;
        logic [1:0]                    count;
    } bde_bundle_t;

endpackage

// ===== rtl/core/bde_in_if.sv =====
// ----------------------------------------------------------------------------
// bde_in_if: raw byte channel
// Valid/ready channel carrying one raw byte and its end-of-string flag.
// ----------------------------------------------------------------------------
interface bde_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/core/bde_out_if.sv =====
// ----------------------------------------------------------------------------
// bde_out_if: decoded byte channel
// Valid/ready channel carrying one decoded byte and its terminator flag.
// ----------------------------------------------------------------------------
interface bde_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/core/backslash_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// backslash_escape_decoder: streaming C-style escape decoder
// Turns raw bytes into unescaped bytes and closes each string with a zero.
//
//   Channel    Dir   Handshake        Payload
//   in_ch      in    valid/ready      in_byte[7:0], in_last
//   out_ch     out   valid/ready      out_byte[7:0], out_last
//   cfg        in    cfg_we           cfg_data[7:0] (color escape code)
//
// A request is held in the input register and decoded into the result buffer,
// which offers its first result. A request yields zero to three results, one
// per cycle while out_ch is ready, so the rate is one request per cycle while
// each yields at most one result and the output does not stall.
// The result buffer sets the rate: it takes a new request as its last result
// leaves. Reset clears the decoder state and sets the color code to 28.
// ----------------------------------------------------------------------------
module backslash_escape_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    bde_in_if.sink     in_ch,
    bde_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data
);

    logic                 advance;
    logic                 item_valid;
    logic [7:0]           item_byte;
    logic                 item_last;
    bde_pkg::bde_bundle_t bundle;

    // Input register
    bde_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .advance    (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_last  (item_last)
    );

    // Decode step and state
    bde_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item_byte (item_byte),
        .item_last (item_last),
        .bundle    (bundle)
    );

    // Result buffer
    bde_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .bundle     (bundle),
        .advance    (advance),
        .out_ch     (out_ch)
    );

endmodule

// ===== rtl/core/bde_in_stage.sv =====
// ----------------------------------------------------------------------------
// bde_in_stage: input register
// Holds one raw byte request until the decoder takes it.
// ----------------------------------------------------------------------------
module bde_in_stage
(
    input  logic         clk,
    input  logic         rst_n,
    bde_in_if.sink       in_ch,
    input  logic         advance,
    output logic         item_valid,
    output logic [7:0]   item_byte,
    output logic         item_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;

    // Take a new request when empty or when the held one leaves this cycle
    assign in_ch.ready = !valid_reg || advance;
    assign load        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= in_ch.in_byte;
            last_reg <= in_ch.in_last;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_last  = last_reg;

endmodule

// ===== rtl/core/bde_decode.sv =====
// ----------------------------------------------------------------------------
// bde_decode: escape decode step
// Decoder state, color register and the per-byte decode into a result bundle.
// ----------------------------------------------------------------------------
module bde_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    input  logic               advance,
    input  logic [7:0]         item_byte,
    input  logic               item_last,
    output bde_pkg::bde_bundle_t bundle
);

    typedef struct packed {
        bde_pkg::bde_state_t  st;
        bde_pkg::bde_bundle_t bun;
    } step_t;

    bde_pkg::bde_state_t state_reg;
    bde_pkg::bde_state_t state_next;
    logic [7:0]          color_reg;
    step_t               pass1;
    step_t               pass2;

    // Append one result to a bundle
    function automatic bde_pkg::bde_bundle_t put(input bde_pkg::bde_bundle_t bin,
                                                 input logic [7:0] b,
                                                 input logic last);
        bde_pkg::bde_bundle_t r;
        r = bin;
        if (r.count != 2'd3)
        begin
            r.slot[r.count] = '{out_byte: b, out_last: last};
            r.count         = r.count + 2'd1;
        end
        return r;
    endfunction

    // Hex digit value; bit 4 set means not a digit
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] d;
        d = 5'd16;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            d = {1'b0, b[3:0]};
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
        begin
            d = {1'b0, b[3:0] + 4'd9};
        end
        return d;
    endfunction

    // Decode one byte against a state; zero ends the string
    function automatic step_t process(input bde_pkg::bde_state_t s,
                                      input bde_pkg::bde_bundle_t bin,
                                      input logic [7:0] b,
                                      input logic last,
                                      input logic [7:0] color);
        step_t      r;
        logic       done;
        logic       hex;
        logic [7:0] v;
        logic [4:0] d;
        logic [1:0] cnt;
        r    = '{st: s, bun: bin};
        done = 1'b0;
        hex  = 1'b0;
        v    = '0;
        d    = '0;
        cnt  = '0;

        // Pending color byte goes out unless the string ends here
        if (r.st.held_valid)
        begin
            if (b == bde_pkg::CHAR_NUL)
            begin
                r.st  = '0;
                r.bun = put(r.bun, 8'h00, 1'b1);
                done  = 1'b1;
            end
            else
            begin
                r.bun           = put(r.bun, r.st.held_byte, 1'b0);
                r.st.held_valid = 1'b0;
                r.st.held_byte  = '0;
            end
        end

        // Numeric escape: shift, then check for a digit
        if (!done && (r.st.mode == bde_pkg::MODE_HEX || r.st.mode == bde_pkg::MODE_OCT))
        begin
            hex = (r.st.mode == bde_pkg::MODE_HEX);
            v   = hex ? {r.st.value[3:0], 4'h0} : {r.st.value[4:0], 3'b000};
            if (hex)
            begin
                d = hex_val(b);
            end
            else if (b[7:3] == 5'b00110)
            begin
                d = {2'b00, b[2:0]};
            end
            else
            begin
                d = 5'd16;
            end
            if (!d[4])
            begin
                v           = v + {4'h0, d[3:0]};
                cnt         = r.st.count + 2'd1;
                r.st.value  = v;
                r.st.count  = cnt;
                if (cnt >= (hex ? 2'd2 : 2'd3))
                begin
                    r.bun      = put(r.bun, v, 1'b0);
                    r.st.mode  = bde_pkg::MODE_PLAIN;
                    r.st.value = '0;
                    r.st.count = '0;
                end
                done = 1'b1;
            end
            else
            begin
                r.bun      = put(r.bun, v, 1'b0);
                r.st.mode  = bde_pkg::MODE_PLAIN;
                r.st.value = '0;
                r.st.count = '0;
            end
        end

        // End of string
        if (!done && b == bde_pkg::CHAR_NUL)
        begin
            r.st  = '0;
            r.bun = put(r.bun, 8'h00, 1'b1);
            done  = 1'b1;
        end

        // Plain text
        if (!done && r.st.mode == bde_pkg::MODE_PLAIN)
        begin
            if (b == bde_pkg::CHAR_BACKSLASH)
            begin
                r.st.mode = bde_pkg::MODE_ESC;
            end
            else
            begin
                r.bun = put(r.bun, b, 1'b0);
            end
            done = 1'b1;
        end

        // Byte after a backslash
        if (!done)
        begin
            r.st.mode = bde_pkg::MODE_PLAIN;
            if (b == bde_pkg::CHAR_C)
            begin
                if (!last)
                begin
                    r.st.held_byte  = color;
                    r.st.held_valid = 1'b1;
                end
            end
            else if (b == bde_pkg::CHAR_N)
            begin
                r.bun = put(r.bun, bde_pkg::CODE_LF, 1'b0);
            end
            else if (b == bde_pkg::CHAR_T)
            begin
                r.bun = put(r.bun, bde_pkg::CODE_HT, 1'b0);
            end
            else if (b == bde_pkg::CHAR_R)
            begin
                r.bun = put(r.bun, bde_pkg::CODE_CR, 1'b0);
            end
            else if (b == bde_pkg::CHAR_X_LOWER || b == bde_pkg::CHAR_X_UPPER)
            begin
                r.st.mode  = bde_pkg::MODE_HEX;
                r.st.value = '0;
                r.st.count = '0;
            end
            else if (b[7:3] == 5'b00110)
            begin
                r.st.mode  = bde_pkg::MODE_OCT;
                r.st.value = {5'b00000, b[2:0]};
                r.st.count = 2'd1;
            end
            else
            begin
                r.bun = put(r.bun, b, 1'b0);
            end
        end
        return r;
    endfunction

    // Byte itself, then an implied terminator after a nonzero last byte
    always_comb
    begin
        pass1 = process(state_reg, '0, item_byte, item_last, color_reg);
        pass2 = pass1;
        if (item_byte != bde_pkg::CHAR_NUL && item_last)
        begin
            pass2 = process(pass1.st, pass1.bun, bde_pkg::CHAR_NUL, 1'b1, color_reg);
        end
        state_next = advance ? pass2.st : state_reg;
    end

    assign bundle = pass2.bun;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            color_reg <= bde_pkg::COLOR_CODE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                color_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== rtl/core/bde_out_buf.sv =====
// ----------------------------------------------------------------------------
// bde_out_buf: result buffer
// Holds the results of one request and hands them out one per cycle while out_ch is ready.
// ----------------------------------------------------------------------------
module bde_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  bde_pkg::bde_bundle_t bundle,
    output logic                 advance,
    bde_out_if.source            out_ch
);

    bde_pkg::bde_result_t [bde_pkg::MAX_RESULTS-1:0] slot_reg;
    bde_pkg::bde_result_t [bde_pkg::MAX_RESULTS-1:0] slot_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       fire;
    logic       can_load;

    assign out_ch.valid    = (count_reg != 2'd0);
    assign out_ch.out_byte = slot_reg[0].out_byte;
    assign out_ch.out_last = slot_reg[0].out_last;
    assign fire            = out_ch.valid && out_ch.ready;

    // Room for a new bundle once the last held result leaves
    assign can_load = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ch.ready);
    assign advance  = item_valid && can_load;

    always_comb
    begin
        slot_next  = slot_reg;
        count_next = count_reg;
        if (advance)
        begin
            slot_next  = bundle.slot;
            count_next = bundle.count;
        end
        else if (fire)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            count_next   = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the backslash escape decoder
// Streams raw strings through the decoder under bursty input and stalling
// output, predicts every decoded byte and terminator, and compares results in
// order. A directed pass covers each escape form and the odd endings; random
// strings follow under several color codes and idling styles.
// ----------------------------------------------------------------------------
module testbench;

    // Digits and letters used by the numeric escapes
    localparam logic [7:0] CHAR_0       = "0";
    localparam logic [7:0] CHAR_7       = "7";
    localparam logic [7:0] CHAR_8       = "8";
    localparam logic [7:0] CHAR_9       = "9";
    localparam logic [7:0] CHAR_A_LOWER = "a";
    localparam logic [7:0] CHAR_F_LOWER = "f";
    localparam logic [7:0] CHAR_G_LOWER = "g";
    localparam logic [7:0] CHAR_A_UPPER = "A";
    localparam logic [7:0] CHAR_F_UPPER = "F";
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TILDE   = 8'h7E;

    localparam int NO_DIGIT      = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 80;
    localparam int RUN_LIMIT_NS  = 3000000;

    typedef enum int {
        RX_ALWAYS,
        RX_PATTERN,
        RX_RANDOM
    } rx_style_e;

    // ------------------------------------------------------------------------
    // Scoreboard: unescapes each accepted request and checks results in order
    // ------------------------------------------------------------------------
    class escape_checker;
        logic [7:0]           color_code;
        logic [1:0]           mode;
        logic [7:0]           accum;
        logic [1:0]           digits;
        logic [7:0]           held_code;
        bit                   held;
        bde_pkg::bde_result_t expected_bytes[$];
        int                   fail_count;
        int                   request_count;
        int                   byte_count;
        int                   terminator_count;

        function new();
            color_code       = bde_pkg::COLOR_CODE_RESET;
            fail_count       = 0;
            request_count    = 0;
            byte_count       = 0;
            terminator_count = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode      = bde_pkg::MODE_PLAIN;
            accum     = 8'd0;
            digits    = 2'd0;
            held_code = 8'd0;
            held      = 1'b0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void push_expected(logic [7:0] b, logic l);
            bde_pkg::bde_result_t r;
            r.out_byte = b;
            r.out_last = l;
            expected_bytes.push_back(r);
        endfunction

        // Value of b as a digit of the current radix, NO_DIGIT if it is none
        function int digit_value(logic [7:0] b, bit hex);
            if (!hex)
                return (b >= CHAR_0 && b <= CHAR_7) ? int'(b - CHAR_0) : NO_DIGIT;
            if (b >= CHAR_0 && b <= CHAR_9)
                return int'(b - CHAR_0);
            if (b >= CHAR_A_LOWER && b <= CHAR_F_LOWER)
                return 10 + int'(b - CHAR_A_LOWER);
            if (b >= CHAR_A_UPPER && b <= CHAR_F_UPPER)
                return 10 + int'(b - CHAR_A_UPPER);
            return NO_DIGIT;
        endfunction

        // One raw byte through the decoder; zero ends the string
        function void unescape_byte(logic [7:0] b, bit last_flag);
            logic [7:0] v;
            int         d;
            bit         hex;

            // a held color byte is flushed unless the string ends here
            if (held)
            begin
                if (b == bde_pkg::CHAR_NUL)
                begin
                    clear_state();
                    push_expected(bde_pkg::CHAR_NUL, 1'b1);
                    return;
                end
                push_expected(held_code, 1'b0);
                held      = 1'b0;
                held_code = 8'd0;
            end

            // numeric escape: shift first, then test the digit
            if (mode == bde_pkg::MODE_HEX || mode == bde_pkg::MODE_OCT)
            begin
                hex = (mode == bde_pkg::MODE_HEX);
                v   = hex ? (accum << 4) : (accum << 3);
                d   = digit_value(b, hex);
                if (d != NO_DIGIT)
                begin
                    v      = v + 8'(d);
                    digits = digits + 2'd1;
                    accum  = v;
                    if (int'(digits) >= (hex ? 2 : 3))
                    begin
                        push_expected(v, 1'b0);
                        mode   = bde_pkg::MODE_PLAIN;
                        accum  = 8'd0;
                        digits = 2'd0;
                    end
                    return;
                end
                // cut short: emit the shifted value, then decode b as text
                push_expected(v, 1'b0);
                mode   = bde_pkg::MODE_PLAIN;
                accum  = 8'd0;
                digits = 2'd0;
            end

            if (b == bde_pkg::CHAR_NUL)
            begin
                clear_state();
                push_expected(bde_pkg::CHAR_NUL, 1'b1);
                return;
            end

            if (mode == bde_pkg::MODE_PLAIN)
            begin
                if (b == bde_pkg::CHAR_BACKSLASH)
                    mode = bde_pkg::MODE_ESC;
                else
                    push_expected(b, 1'b0);
                return;
            end

            // byte after a backslash
            mode = bde_pkg::MODE_PLAIN;
            case (b)
                bde_pkg::CHAR_C:
                    if (!last_flag)
                    begin
                        held_code = color_code;
                        held      = 1'b1;
                    end
                bde_pkg::CHAR_N: push_expected(bde_pkg::CODE_LF, 1'b0);
                bde_pkg::CHAR_T: push_expected(bde_pkg::CODE_HT, 1'b0);
                bde_pkg::CHAR_R: push_expected(bde_pkg::CODE_CR, 1'b0);
                bde_pkg::CHAR_X_LOWER, bde_pkg::CHAR_X_UPPER:
                begin
                    mode   = bde_pkg::MODE_HEX;
                    accum  = 8'd0;
                    digits = 2'd0;
                end
                default:
                    if (b >= CHAR_0 && b <= CHAR_7)
                    begin
                        mode   = bde_pkg::MODE_OCT;
                        accum  = b - CHAR_0;
                        digits = 2'd1;
                    end
                    else
                    begin
                        push_expected(b, 1'b0);
                    end
            endcase
        endfunction

        // Accepted request: a flagged last byte closes the string after it
        function void note_raw_byte(logic [7:0] b, logic l);
            request_count++;
            unescape_byte(b, l);
            if (b != bde_pkg::CHAR_NUL && l)
                unescape_byte(bde_pkg::CHAR_NUL, 1'b1);
        endfunction

        function void check_decoded(logic [7:0] b, logic l);
            bde_pkg::bde_result_t want;
            if (l)
                terminator_count++;
            else
                byte_count++;
            if (expected_bytes.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result: expected none, actual byte %02h last %0d",
                         $time, b, l);
                return;
            end
            want = expected_bytes.pop_front();
            if (b !== want.out_byte)
            begin
                fail_count++;
                $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                         $time, want.out_byte, b);
            end
            if (l !== want.out_last)
            begin
                fail_count++;
                $display("%0t: out_last mismatch: expected %0d, actual %0d",
                         $time, want.out_last, l);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;

    bde_in_if  in_ch ();
    bde_out_if out_ch ();

    escape_checker board = new();

    rx_style_e rx_style      = RX_ALWAYS;
    bit        long_hold_req = 1'b0;
    bit        gaps_on       = 1'b0;
    int        burst_left    = 0;
    int        items_sent    = 0;
    int        color_writes  = 0;

    backslash_escape_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // Handshake monitors
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            board.note_raw_byte(in_ch.in_byte, in_ch.in_last);
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_decoded(out_ch.out_byte, out_ch.out_last);
    end

    // ------------------------------------------------------------------------
    // Receiver: long hold-off on demand, then fixed, patterned or random ready
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int cyc;
        int period;
        int stall_len;
        cyc       = 0;
        period    = 4;
        stall_len = 1;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (cyc % 40 == 0)
            begin
                period    = $urandom_range(2, 8);
                stall_len = $urandom_range(1, period - 1);
            end
            case (rx_style)
                RX_ALWAYS:  out_ch.ready <= 1'b1;
                RX_PATTERN: out_ch.ready <= ((cyc % period) >= stall_len);
                default:    out_ch.ready <= ($urandom_range(0, 9) < 7);
            endcase
            cyc++;
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one request and wait for it to be taken; gaps fall between bursts
    task automatic send_byte(logic [7:0] data, logic last_flag);
        int gap;
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= data;
        in_ch.in_last <= last_flag;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, 6);
                in_ch.valid   <= 1'b0;
                in_ch.in_byte <= 8'($urandom);
                repeat (gap) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Stop offering and let every expected result and the pipeline drain
    task automatic drain_decoder();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_color_code(logic [7:0] code);
        drain_decoder();
        cfg_we   <= 1'b1;
        cfg_data <= code;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.color_code = code;
        color_writes++;
    endtask

    function automatic logic [7:0] hex_char(int k);
        if (k < 10)
            return CHAR_0 + 8'(k);
        if (k < 16)
            return CHAR_A_LOWER + 8'(k - 10);
        return CHAR_A_UPPER + 8'(k - 16);
    endfunction

    // Every escape form and the odd string endings
    task automatic run_directed_strings();
        send_byte(bde_pkg::CHAR_BACKSLASH, 1'b0);
        send_byte(bde_pkg::CHAR_N, 1'b0);
        send_byte(bde_pkg::CHAR_BACKSLASH, 1'b0);
        send_byte(bde_pkg::CHAR_T, 1'b0);
        send_byte(bde_pkg::CHAR_BACKSLASH, 1'b0);
        send_byte(bde_pkg::CHAR_R, 1'b0);
        // x with no hex digit yields zero, then z as text
        send_byte(bde_pkg::CHAR_BACKSLASH, 1'b0);
        send_byte(bde_pkg::CHAR_X_LOWER, 1'b0);
        send_byte("z", 1'b0);
        // two hex digits, mixed case
        send_byte(bde_pkg::CHAR_BACKSLASH, 1'b0);
        send_byte(bde_pkg::CHAR_X_UPPER, 1'b0);
        send_byte(CHAR_F_UPPER, 1'b0);
        send_byte(CHAR_F_LOWER, 1'b0);
        // three octal digits, string closed by the flag
        send_byte(bde_pkg::CHAR_BACKSLASH, 1'b0);
        send_byte("3", 1'b0);
        send_byte(CHAR_7, 1'b0);
        send_byte(CHAR_7, 1'b1);
        // color escape followed by text
        send_byte(bde_pkg::CHAR_BACKSLASH, 1'b0);
        send_byte(bde_pkg::CHAR_C, 1'b0);
        send_byte(8'h7F, 1'b0);
        // octal cut short by a backslash gives a decoded zero; \q is literal
        send_byte(bde_pkg::CHAR_BACKSLASH, 1'b0);
        send_byte(CHAR_0, 1'b0);
        send_byte(bde_pkg::CHAR_BACKSLASH, 1'b0);
        send_byte("q", 1'b0);
        // octal cut short by the end of the string
        send_byte(bde_pkg::CHAR_BACKSLASH, 1'b0);
        send_byte("4", 1'b1);
        // trailing color escape
        send_byte(bde_pkg::CHAR_BACKSLASH, 1'b0);
        send_byte(bde_pkg::CHAR_C, 1'b1);
        // lone trailing backslash, then an empty string
        send_byte(8'hFF, 1'b0);
        send_byte(bde_pkg::CHAR_BACKSLASH, 1'b1);
        send_byte(bde_pkg::CHAR_NUL, 1'b0);
    endtask

    // Mostly well-formed escapes with random content, some noise
    task automatic send_random_string();
        logic [7:0] raw[$];
        int         n_tokens;
        int         n_digits;
        int         pick;
        int         end_style;
        logic       last_flag;
        n_tokens = $urandom_range(1, 8);
        repeat (n_tokens)
        begin
            case ($urandom_range(0, 11))
                0, 1, 2: raw.push_back(8'($urandom_range(CHAR_SPACE, CHAR_TILDE)));
                3:
                begin
                    raw.push_back(bde_pkg::CHAR_BACKSLASH);
                    raw.push_back(bde_pkg::CHAR_C);
                end
                4:
                begin
                    pick = $urandom_range(0, 2);
                    raw.push_back(bde_pkg::CHAR_BACKSLASH);
                    raw.push_back(pick == 0 ? bde_pkg::CHAR_N :
                                  (pick == 1 ? bde_pkg::CHAR_T : bde_pkg::CHAR_R));
                end
                5, 6:
                begin
                    raw.push_back(bde_pkg::CHAR_BACKSLASH);
                    raw.push_back($urandom_range(0, 1) ? bde_pkg::CHAR_X_UPPER :
                                                         bde_pkg::CHAR_X_LOWER);
                    n_digits = $urandom_range(0, 2);
                    repeat (n_digits) raw.push_back(hex_char($urandom_range(0, 21)));
                end
                7:
                begin
                    raw.push_back(bde_pkg::CHAR_BACKSLASH);
                    raw.push_back(CHAR_0 + 8'($urandom_range(0, 7)));
                    n_digits = $urandom_range(0, 2);
                    repeat (n_digits) raw.push_back(CHAR_0 + 8'($urandom_range(0, 7)));
                end
                8:
                begin
                    raw.push_back(bde_pkg::CHAR_BACKSLASH);
                    raw.push_back(8'($urandom_range(1, 255)));
                end
                9: raw.push_back(8'($urandom_range(1, 255)));
                10:
                begin
                    // numeric escape broken by a non-digit
                    raw.push_back(bde_pkg::CHAR_BACKSLASH);
                    if ($urandom_range(0, 1))
                        raw.push_back(bde_pkg::CHAR_X_LOWER);
                    else
                        raw.push_back(CHAR_0 + 8'($urandom_range(0, 7)));
                    pick = $urandom_range(0, 3);
                    raw.push_back(pick == 0 ? CHAR_8 : (pick == 1 ? CHAR_9 :
                                  (pick == 2 ? CHAR_G_LOWER : 8'($urandom_range(1, 255)))));
                end
                default: raw.push_back(8'($urandom));
            endcase
        end
        // end by flag on the last byte, by a zero byte, or by a flagged zero
        end_style = $urandom_range(0, 2);
        if (end_style != 0)
            raw.push_back(bde_pkg::CHAR_NUL);
        foreach (raw[i])
        begin
            if (i == raw.size() - 1)
                last_flag = (end_style != 1);
            else
                last_flag = ($urandom_range(0, 39) == 0);
            send_byte(raw[i], last_flag);
        end
    endtask

    task automatic send_random_strings(int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
            send_random_string();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'd0;
        in_ch.in_last <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_data      <= 8'd0;
        rst_n         <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass with the reset color code
        gaps_on  = 1'b1;
        rx_style = RX_PATTERN;
        run_directed_strings();

        // random passes under different codes and idling
        write_color_code(8'hFF);
        gaps_on  = 1'b0;
        rx_style = RX_ALWAYS;
        send_random_strings(35);

        write_color_code(8'h00);
        gaps_on       = 1'b1;
        rx_style      = RX_PATTERN;
        long_hold_req = 1'b1;
        send_random_strings(35);

        write_color_code(8'($urandom));
        gaps_on  = 1'b1;
        rx_style = RX_RANDOM;
        send_random_strings(35);

        write_color_code(8'($urandom));
        gaps_on  = 1'b0;
        rx_style = RX_PATTERN;
        send_random_strings(35);

        drain_decoder();

        $display("Covered %0d raw bytes, %0d decoded bytes and %0d string terminators",
                 board.request_count, board.byte_count, board.terminator_count);
        $display("Color code rewritten %0d times; input bursts, output stalls and a long hold-off",
                 color_writes);
        if (board.fail_count == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bde_pkg.sv
rtl/core/bde_in_if.sv
rtl/core/bde_out_if.sv
rtl/core/bde_in_stage.sv
rtl/core/bde_decode.sv
rtl/core/bde_out_buf.sv
rtl/core/backslash_escape_decoder.sv
sim/testbench.sv
